[rtl/core/sci_pkg.sv]
// Shared types and constants of the scaled image compositor.
package sci_pkg;

  localparam int POS_W = 12;
  localparam int CH_W = 8;
  localparam int PIX_W = 3 * CH_W;
  localparam int SRC_DIM_W = 10;
  localparam int DST_DIM_W = 12;
  localparam int STEP_W = 20;
  localparam int OFS_W = 12;
  localparam int PROD_W = POS_W + STEP_W;
  localparam int LIM_W = 13;
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PW = $clog2(FIFO_DEPTH);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  localparam logic [2:0] REG_SRC_WIDTH = 3'd0;
  localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [2:0] REG_DST_WIDTH = 3'd2;
  localparam logic [2:0] REG_DST_HEIGHT = 3'd3;
  localparam logic [2:0] REG_X_STEP = 3'd4;
  localparam logic [2:0] REG_Y_STEP = 3'd5;
  localparam logic [2:0] REG_LEFT_OFFSET = 3'd6;
  localparam logic [2:0] REG_TOP_OFFSET = 3'd7;

  typedef struct packed {
    logic vld;
    logic fetch;
    logic hit;
  } ctl_t;

  typedef struct packed {
    logic img;
    logic [PIX_W-1:0] pix;
  } res_t;

endpackage

[rtl/core/sci_if.sv]
// Valid/ready channel interfaces for the input and result transactions.
interface sci_in_if;
  logic valid;
  logic ready;
  logic opcode;
  logic [sci_pkg::POS_W-1:0] pos_x;
  logic [sci_pkg::POS_W-1:0] pos_y;
  logic [sci_pkg::CH_W-1:0] red;
  logic [sci_pkg::CH_W-1:0] green;
  logic [sci_pkg::CH_W-1:0] blue;

  modport source(output valid, opcode, pos_x, pos_y, red, green, blue, input ready);
  modport sink(input valid, opcode, pos_x, pos_y, red, green, blue, output ready);
endinterface

interface sci_out_if;
  logic valid;
  logic ready;
  logic [sci_pkg::CH_W-1:0] pixel_blue;
  logic [sci_pkg::CH_W-1:0] pixel_green;
  logic [sci_pkg::CH_W-1:0] pixel_red;
  logic inside_res;

  modport source(output valid, pixel_blue, pixel_green, pixel_red, inside_res, input ready);
  modport sink(input valid, pixel_blue, pixel_green, pixel_red, inside_res, output ready);
endinterface

[rtl/core/sci_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module sci_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 262144
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/scaled_image_compositor_top.sv]
// Top level of the scaled image compositor with its frame store and result queue.
// A fetch result goes through the pipeline and then the result queue to the output.
// Throughput: one transaction per cycle while the input is ready, loads and fetches
// alike, through a six-stage pipeline around the simple dual-port frame store; an
// eight-entry result queue caps the outstanding fetches. Synchronous reset clears the
// registers, the pipeline and the queue; the frame store holds no reset value.
module scaled_image_compositor_top #(
  parameter int MAX_SRC_WIDTH = 512,
  parameter int MAX_SRC_HEIGHT = 512,
  parameter int RATIO_FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  sci_in_if.sink                      in_chan,
  sci_out_if.source                   out_chan,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sci_pkg::CFG_AW-1:0]  paddr,
  input  logic [sci_pkg::CFG_DW-1:0]  pwdata,
  output logic [sci_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);

  localparam int XW = $clog2(MAX_SRC_WIDTH);
  localparam int YW = $clog2(MAX_SRC_HEIGHT);
  localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int AW = $clog2(DEPTH);
  localparam int POS_W = sci_pkg::POS_W;
  localparam int PROD_W = sci_pkg::PROD_W;
  localparam int LIM_W = sci_pkg::LIM_W;
  localparam int PIX_W = sci_pkg::PIX_W;
  localparam int CNT_W = sci_pkg::FIFO_PW + 1;

  logic [sci_pkg::SRC_DIM_W-1:0] src_width_r, src_height_r;
  logic [sci_pkg::DST_DIM_W-1:0] dst_width_r, dst_height_r;
  logic [sci_pkg::STEP_W-1:0]    x_step_r, y_step_r;
  logic [sci_pkg::OFS_W-1:0]     left_offset_r, top_offset_r;

  logic cfg_wr;
  logic [2:0] cfg_idx;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r <= sci_pkg::SRC_DIM_W'(512);
      src_height_r <= sci_pkg::SRC_DIM_W'(512);
      dst_width_r <= sci_pkg::DST_DIM_W'(512);
      dst_height_r <= sci_pkg::DST_DIM_W'(512);
      x_step_r <= sci_pkg::STEP_W'(65536);
      y_step_r <= sci_pkg::STEP_W'(65536);
      left_offset_r <= '0;
      top_offset_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        sci_pkg::REG_SRC_WIDTH:   src_width_r <= pwdata[sci_pkg::SRC_DIM_W-1:0];
        sci_pkg::REG_SRC_HEIGHT:  src_height_r <= pwdata[sci_pkg::SRC_DIM_W-1:0];
        sci_pkg::REG_DST_WIDTH:   dst_width_r <= pwdata[sci_pkg::DST_DIM_W-1:0];
        sci_pkg::REG_DST_HEIGHT:  dst_height_r <= pwdata[sci_pkg::DST_DIM_W-1:0];
        sci_pkg::REG_X_STEP:      x_step_r <= pwdata[sci_pkg::STEP_W-1:0];
        sci_pkg::REG_Y_STEP:      y_step_r <= pwdata[sci_pkg::STEP_W-1:0];
        sci_pkg::REG_LEFT_OFFSET: left_offset_r <= pwdata[sci_pkg::OFS_W-1:0];
        sci_pkg::REG_TOP_OFFSET:  top_offset_r <= pwdata[sci_pkg::OFS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      sci_pkg::REG_SRC_WIDTH:   prdata = sci_pkg::CFG_DW'(src_width_r);
      sci_pkg::REG_SRC_HEIGHT:  prdata = sci_pkg::CFG_DW'(src_height_r);
      sci_pkg::REG_DST_WIDTH:   prdata = sci_pkg::CFG_DW'(dst_width_r);
      sci_pkg::REG_DST_HEIGHT:  prdata = sci_pkg::CFG_DW'(dst_height_r);
      sci_pkg::REG_X_STEP:      prdata = sci_pkg::CFG_DW'(x_step_r);
      sci_pkg::REG_Y_STEP:      prdata = sci_pkg::CFG_DW'(y_step_r);
      sci_pkg::REG_LEFT_OFFSET: prdata = sci_pkg::CFG_DW'(left_offset_r);
      sci_pkg::REG_TOP_OFFSET:  prdata = sci_pkg::CFG_DW'(top_offset_r);
      default:                  prdata = '0;
    endcase
  end

  // Result credit: fetches in flight plus queued results never exceed the queue depth.
  logic [CNT_W-1:0] pend_r, pend_nxt;
  logic in_acc, in_fetch, pop;

  assign in_chan.ready = (pend_r < CNT_W'(sci_pkg::FIFO_DEPTH));
  assign in_acc = in_chan.valid & in_chan.ready;
  assign in_fetch = in_acc & (in_chan.opcode == sci_pkg::OP_FETCH);

  // Stage 1: captured transaction.
  sci_pkg::ctl_t s1_ctl_r;
  logic [POS_W-1:0] s1_px_r, s1_py_r;
  logic [PIX_W-1:0] s1_pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
    end else begin
      s1_ctl_r <= '{vld: in_acc, fetch: in_chan.opcode == sci_pkg::OP_FETCH, hit: 1'b0};
    end
    s1_px_r <= in_chan.pos_x;
    s1_py_r <= in_chan.pos_y;
    s1_pix_r <= {in_chan.red, in_chan.green, in_chan.blue};
  end

  // Stage 2: rectangle test for fetches, range test for loads.
  logic signed [POS_W+1:0] ix, iy;
  logic in_rect, ld_ok;
  sci_pkg::ctl_t s2_ctl_r;
  logic [POS_W-1:0] s2_cx_r, s2_cy_r;
  logic [PIX_W-1:0] s2_pix_r;

  always_comb begin
    ix = $signed({2'b00, s1_px_r}) - (POS_W+2)'($signed(left_offset_r));
    iy = $signed({2'b00, s1_py_r}) - (POS_W+2)'($signed(top_offset_r));
    in_rect = !ix[POS_W+1] && !iy[POS_W+1]
              && (ix[POS_W:0] < {1'b0, dst_width_r})
              && (iy[POS_W:0] < {1'b0, dst_height_r});
    ld_ok = ({1'b0, s1_px_r} < (POS_W+1)'(MAX_SRC_WIDTH))
            && ({1'b0, s1_py_r} < (POS_W+1)'(MAX_SRC_HEIGHT));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_ctl_r <= '0;
    end else begin
      s2_ctl_r <= '{vld: s1_ctl_r.vld, fetch: s1_ctl_r.fetch,
                    hit: s1_ctl_r.fetch ? in_rect : ld_ok};
    end
    s2_cx_r <= s1_ctl_r.fetch ? ix[POS_W-1:0] : s1_px_r;
    s2_cy_r <= s1_ctl_r.fetch ? iy[POS_W-1:0] : s1_py_r;
    s2_pix_r <= s1_pix_r;
  end

  // Stage 3: image coordinate times ratio.
  sci_pkg::ctl_t s3_ctl_r;
  logic [PROD_W-1:0] s3_prod_x_r, s3_prod_y_r;
  logic [POS_W-1:0] s3_cx_r, s3_cy_r;
  logic [PIX_W-1:0] s3_pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_ctl_r <= '0;
    end else begin
      s3_ctl_r <= s2_ctl_r;
    end
    s3_prod_x_r <= PROD_W'(s2_cx_r) * PROD_W'(x_step_r);
    s3_prod_y_r <= PROD_W'(s2_cy_r) * PROD_W'(y_step_r);
    s3_cx_r <= s2_cx_r;
    s3_cy_r <= s2_cy_r;
    s3_pix_r <= s2_pix_r;
  end

  // Stage 4: for fetches, floor and clamp to the source size; loads keep their coordinates.
  logic [LIM_W-1:0] lim_x, lim_y, lim_x_m1, lim_y_m1;
  logic [PROD_W-1:0] fl_x, fl_y, cl_x, cl_y;
  sci_pkg::ctl_t s4_ctl_r;
  logic [XW-1:0] s4_sx_r;
  logic [YW-1:0] s4_sy_r;
  logic [PIX_W-1:0] s4_pix_r;

  always_comb begin
    lim_x = (LIM_W'(src_width_r) < LIM_W'(MAX_SRC_WIDTH)) ? LIM_W'(src_width_r)
                                                          : LIM_W'(MAX_SRC_WIDTH);
    lim_y = (LIM_W'(src_height_r) < LIM_W'(MAX_SRC_HEIGHT)) ? LIM_W'(src_height_r)
                                                            : LIM_W'(MAX_SRC_HEIGHT);
    if (lim_x == '0) begin
      lim_x = LIM_W'(1);
    end
    if (lim_y == '0) begin
      lim_y = LIM_W'(1);
    end
    lim_x_m1 = lim_x - LIM_W'(1);
    lim_y_m1 = lim_y - LIM_W'(1);
    fl_x = s3_prod_x_r >> RATIO_FRAC_BITS;
    fl_y = s3_prod_y_r >> RATIO_FRAC_BITS;
    cl_x = (fl_x > PROD_W'(lim_x_m1)) ? PROD_W'(lim_x_m1) : fl_x;
    cl_y = (fl_y > PROD_W'(lim_y_m1)) ? PROD_W'(lim_y_m1) : fl_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_ctl_r <= '0;
    end else begin
      s4_ctl_r <= s3_ctl_r;
    end
    s4_sx_r <= s3_ctl_r.fetch ? cl_x[XW-1:0] : s3_cx_r[XW-1:0];
    s4_sy_r <= s3_ctl_r.fetch ? cl_y[YW-1:0] : s3_cy_r[YW-1:0];
    s4_pix_r <= s3_pix_r;
  end

  // Stage 5: frame store address.
  sci_pkg::ctl_t s5_ctl_r;
  logic [AW-1:0] s5_addr_r;
  logic [PIX_W-1:0] s5_pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_ctl_r <= '0;
    end else begin
      s5_ctl_r <= s4_ctl_r;
    end
    s5_addr_r <= AW'(AW'(s4_sy_r) * AW'(MAX_SRC_WIDTH)) + AW'(s4_sx_r);
    s5_pix_r <= s4_pix_r;
  end

  // Stage 6: frame store access; loads write and fetches read in program order.
  logic ram_we, ram_re;
  logic [PIX_W-1:0] ram_rdata;
  sci_pkg::ctl_t s6_ctl_r;

  assign ram_we = s5_ctl_r.vld & !s5_ctl_r.fetch & s5_ctl_r.hit;
  assign ram_re = s5_ctl_r.vld & s5_ctl_r.fetch & s5_ctl_r.hit;

  sci_ram #(
    .WIDTH(PIX_W),
    .DEPTH(DEPTH)
  ) u_frame_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(s5_addr_r),
    .wdata(s5_pix_r),
    .re   (ram_re),
    .raddr(s5_addr_r),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_ctl_r <= '0;
    end else begin
      s6_ctl_r <= s5_ctl_r;
    end
  end

  // Result queue.
  sci_pkg::res_t fifo_q [sci_pkg::FIFO_DEPTH];
  sci_pkg::res_t push_res, head;
  logic [sci_pkg::FIFO_PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic push;

  assign push = s6_ctl_r.vld & s6_ctl_r.fetch;
  assign push_res = '{img: s6_ctl_r.hit, pix: s6_ctl_r.hit ? ram_rdata : '0};
  assign head = fifo_q[rd_ptr_r];
  assign pop = out_chan.valid & out_chan.ready;

  assign out_chan.valid = (cnt_r != '0);
  assign out_chan.pixel_red = head.pix[PIX_W-1 -: sci_pkg::CH_W];
  assign out_chan.pixel_green = head.pix[2*sci_pkg::CH_W-1 -: sci_pkg::CH_W];
  assign out_chan.pixel_blue = head.pix[sci_pkg::CH_W-1:0];
  assign out_chan.inside_res = head.img;

  always_comb begin
    cnt_nxt = cnt_r + CNT_W'(push) - CNT_W'(pop);
    pend_nxt = pend_r + CNT_W'(in_fetch) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
      pend_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + sci_pkg::FIFO_PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + sci_pkg::FIFO_PW'(1);
      end
      cnt_r <= cnt_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_q[wr_ptr_r] <= push_res;
    end
  end

endmodule

[rtl/core/sci_checker.sv]
// Port-level checker for the scaled image compositor and its bind to the top level.
module sci_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [sci_pkg::CH_W-1:0]  pixel_blue,
  input logic [sci_pkg::CH_W-1:0]  pixel_green,
  input logic [sci_pkg::CH_W-1:0]  pixel_red,
  input logic                      inside_res,
  input logic                      pready
);

  // A result transaction that is stalled keeps its valid and its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(pixel_blue) && $stable(pixel_green)
      && $stable(pixel_red) && $stable(inside_res))
    else $error("result transaction changed while stalled");

  // A background result is black.
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !inside_res |-> pixel_blue == '0 && pixel_green == '0 && pixel_red == '0)
    else $error("background result is not black");

  // Reset empties the result queue.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // The configuration port never inserts wait states.
  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("configuration port not ready");

endmodule

bind scaled_image_compositor_top sci_checker u_sci_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .pixel_blue (out_chan.pixel_blue),
  .pixel_green(out_chan.pixel_green),
  .pixel_red  (out_chan.pixel_red),
  .inside_res (out_chan.inside_res),
  .pready     (pready)
);
